// ===== design/kf3_pkg.sv =====
package kf3_pkg;

  localparam int W = 48;
  localparam int CFG_IDX_W = 3;
  localparam logic signed [W-1:0] MAX48 = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN48 = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE_Q32 = 48'sd4294967296;
  localparam logic signed [W-1:0] C_DT = 48'sd42949673;
  localparam logic signed [W-1:0] C_HDT2 = 48'sd214748;
  localparam logic signed [W-1:0] P_RESET = 48'sd42949672960;

  localparam logic [CFG_IDX_W-1:0] REG_GPOS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GBIAS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RN = 3'd4;

  typedef logic signed [W-1:0] val_t;

  // transition matrix entry, row major
  function automatic val_t phi(input logic [3:0] k);
    case (k)
      4'd0, 4'd4, 4'd8: phi = ONE_Q32;
      4'd1: phi = C_DT;
      4'd2: phi = -C_HDT2;
      4'd5: phi = -C_DT;
      default: phi = '0;
    endcase
  endfunction

  function automatic val_t psi(input logic [1:0] i);
    case (i)
      2'd0: psi = C_HDT2;
      2'd1: psi = C_DT;
      default: psi = '0;
    endcase
  endfunction

  function automatic val_t sat48(input logic signed [W+3:0] v);
    if (v > $signed({{4{1'b0}}, MAX48})) sat48 = MAX48;
    else if (v < $signed({{4{1'b1}}, MIN48})) sat48 = MIN48;
    else sat48 = v[W-1:0];
  endfunction

endpackage

// ===== design/kalman_filter_three_state_unit.sv =====
// channel   dir  fields (lsb first)
// s_axis    in   tdata: accel[31:0], position_meas[63:32]
// m_axis    out  tdata: position_est[31:0]
// cfg       in   cfg_we, cfg_index, cfg_data (gamma_pos..measure_noise)
//
// each item runs 87 products through one
// shared 32x32 multiplier plus three gain divisions
// s_axis_tready is low from the accepted transfer until the result is registered
// synchronous reset restores the state vector, covariance and registers
// a stalled result holds on m_axis while the next item runs, which then waits for it
module kalman_filter_three_state_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // accel, position_meas
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // position_est
  input  logic        cfg_we,
  input  logic [kf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import kf3_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_XP, S_AP, S_PP, S_DIV, S_XU, S_PU, S_OUT
  } state_t;

  state_t st;
  logic signed [31:0] gam [3];
  logic [31:0] qn, rn;
  val_t x [3];
  val_t p [9];
  val_t a [9];
  val_t k [3];
  val_t z;
  logic signed [W:0] innov;
  logic signed [W+3:0] acc;
  logic [1:0] ri, ci, mi;
  logic first;
  logic signed [31:0] u;

  logic mstart, mdone, dstart, ddone;
  logic signed [63:0] ma, mb;
  logic [5:0] msh;
  val_t mres, dres;
  logic signed [W:0] dd;

  logic [3:0] rc, rm, cj, jm;

  always_comb begin
    rc = 4'(ri) * 4'd3 + 4'(ci);
    rm = 4'(ri) * 4'd3 + 4'(mi);
    cj = 4'(mi) * 4'd3 + 4'(ci);
    jm = 4'(ci) * 4'd3 + 4'(mi);
    dd = (W+1)'(p[0]) + $signed({17'd0, rn});
    ma = '0; mb = '0; msh = 6'd32;
    case (st)
      S_XP: if (first) begin
        ma = 64'(psi(ri)); mb = 64'(u); msh = 6'd16;
      end else begin
        ma = 64'(phi(rm)); mb = 64'(x[mi]);
      end
      S_AP: begin ma = 64'(phi(rm)); mb = 64'(p[cj]); end
      S_PP: if (first) begin
        ma = 64'(gam[ri]) * 64'(gam[ci]); mb = {32'd0, qn}; msh = 6'd56;
      end else begin
        ma = 64'(a[rm]); mb = 64'(phi(jm));
      end
      S_XU: begin ma = 64'(k[ri]); mb = 64'(innov); end
      S_PU: begin ma = 64'(k[ri]); mb = 64'(a[ci]); end
      default: ;
    endcase
  end

  kf3_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .sh(msh),
    .done(mdone), .res(mres)
  );

  kf3_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .n(p[4'(ri) * 4'd3]), .d(dd),
    .done(ddone), .q(dres)
  );

  logic signed [W+3:0] accn;
  logic signed [W+3:0] rnd0;
  always_comb begin
    accn = acc + (W+4)'(mres);
    if (x[0][W-1]) rnd0 = -(((W+4)'(32768) - (W+4)'(x[0])) >>> 16);
    else rnd0 = ((W+4)'(x[0]) + (W+4)'(32768)) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      s_axis_tready <= 1'b1;
      m_axis_tvalid <= 1'b0;
      mstart <= 1'b0;
      dstart <= 1'b0;
      gam[0] <= 32'sd8053064;
      gam[1] <= -32'sd671089;
      gam[2] <= '0;
      qn <= 32'd1099512;
      rn <= 32'd36936719;
      for (int i = 0; i < 3; i++) x[i] <= '0;
      for (int i = 0; i < 9; i++) p[i] <= P_RESET;
    end else begin
      mstart <= 1'b0;
      dstart <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_GPOS: gam[0] <= cfg_data;
          REG_GVEL: gam[1] <= cfg_data;
          REG_GBIAS: gam[2] <= cfg_data;
          REG_QN: qn <= cfg_data;
          REG_RN: rn <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && st != S_OUT) m_axis_tvalid <= 1'b0;
      case (st)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          s_axis_tready <= 1'b0;
          u <= s_axis_tdata[31:0];
          z <= val_t'($signed(s_axis_tdata[63:32])) <<< 16;
          ri <= '0; ci <= '0; mi <= '0; first <= 1'b1; acc <= '0;
          mstart <= 1'b1;
          st <= S_XP;
        end
        // x = psi*u + phi*x, psi term first, then three phi terms per row
        S_XP: if (mdone) begin
          if (!first && mi == 2'd2) begin
            a[ri] <= sat48(accn);
            acc <= '0; mi <= '0;
            if (ri == 2'd2) begin
              x[0] <= a[0]; x[1] <= a[1]; x[2] <= sat48(accn);
              ri <= '0; ci <= '0; first <= 1'b0;
              st <= S_AP;
            end else begin
              ri <= ri + 2'd1; first <= 1'b1;
            end
          end else begin
            acc <= accn;
            if (!first) mi <= mi + 2'd1;
            first <= 1'b0;
          end
          mstart <= 1'b1;
        end
        S_AP: if (mdone) begin
          if (mi == 2'd2) begin
            a[rc] <= sat48(accn);
            acc <= '0; mi <= '0;
            if (ci == 2'd2) begin
              ci <= '0;
              if (ri == 2'd2) begin ri <= '0; first <= 1'b1; st <= S_PP; end
              else ri <= ri + 2'd1;
            end else ci <= ci + 2'd1;
          end else begin
            acc <= accn; mi <= mi + 2'd1;
          end
          mstart <= 1'b1;
        end
        S_PP: if (mdone) begin
          if (!first && mi == 2'd2) begin
            p[rc] <= sat48(accn);
            acc <= '0; mi <= '0; first <= 1'b1;
            if (ci == 2'd2) begin
              ci <= '0;
              if (ri == 2'd2) begin
                ri <= '0; st <= S_DIV; dstart <= 1'b1;
              end else begin
                ri <= ri + 2'd1; mstart <= 1'b1;
              end
            end else begin
              ci <= ci + 2'd1; mstart <= 1'b1;
            end
          end else begin
            acc <= accn;
            if (!first) mi <= mi + 2'd1;
            first <= 1'b0;
            mstart <= 1'b1;
          end
        end
        S_DIV: if (ddone) begin
          k[ri] <= dres;
          if (ri == 2'd2) begin
            ri <= '0;
            innov <= (W+1)'(z) - (W+1)'(x[0]);
            st <= S_XU;
            mstart <= 1'b1;
          end else begin
            ri <= ri + 2'd1; dstart <= 1'b1;
          end
        end
        S_XU: if (mdone) begin
          x[ri] <= sat48((W+4)'(x[ri]) + (W+4)'(mres));
          if (ri == 2'd2) begin
            ri <= '0; ci <= '0; st <= S_PU;
            a[0] <= p[0]; a[1] <= p[1]; a[2] <= p[2];
          end else ri <= ri + 2'd1;
          mstart <= 1'b1;
        end
        // row zero is kept in a[0..2] as p changes under the update
        S_PU: if (mdone) begin
          p[rc] <= sat48((W+4)'(p[rc]) - (W+4)'(mres));
          if (ci == 2'd2) begin
            ci <= '0;
            if (ri == 2'd2) begin ri <= '0; st <= S_OUT; end
            else begin ri <= ri + 2'd1; mstart <= 1'b1; end
          end else begin
            ci <= ci + 2'd1; mstart <= 1'b1;
          end
        end
        // waits here while the previous result is still held
        S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          if (rnd0 > (W+4)'(32'sh7FFFFFFF)) m_axis_tdata <= 32'h7FFFFFFF;
          else if (rnd0 < -(W+4)'(33'sh80000000)) m_axis_tdata <= 32'h80000000;
          else m_axis_tdata <= rnd0[31:0];
          m_axis_tvalid <= 1'b1;
          s_axis_tready <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/kf3_mul.sv =====
// product of two signed values, shifted right with round half away from zero,
// saturated to 48 bits; the magnitudes are multiplied 32 bits at a time
module kf3_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [63:0]    a,
  input  logic signed [63:0]    b,
  input  logic [5:0]            sh,
  output logic                  done,
  output kf3_pkg::val_t         res
);
  import kf3_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_P0, M_P1, M_P2, M_P3, M_FIN} mstate_t;

  mstate_t st;
  logic neg;
  logic [63:0] ua, ub;
  logic [127:0] acc;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [127:0] rnd;
  logic [127:0] sft;
  logic [47:0] cap;

  always_comb begin
    case (st)
      M_P0: begin ma = ua[31:0]; mb = ub[31:0]; end
      M_P1: begin ma = ua[31:0]; mb = ub[63:32]; end
      M_P2: begin ma = ua[63:32]; mb = ub[31:0]; end
      default: begin ma = ua[63:32]; mb = ub[63:32]; end
    endcase
    prod = 64'(ma) * 64'(mb);
    rnd = acc + (128'd1 << (sh - 6'd1));
    sft = rnd >> sh;
    cap = neg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= M_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        M_IDLE: if (start) begin
          neg <= a[63] ^ b[63];
          ua <= a[63] ? 64'(-a) : 64'(a);
          ub <= b[63] ? 64'(-b) : 64'(b);
          acc <= '0;
          st <= M_P0;
        end
        M_P0: begin acc <= acc + 128'(prod); st <= M_P1; end
        M_P1: begin acc <= acc + (128'(prod) << 32); st <= M_P2; end
        M_P2: begin acc <= acc + (128'(prod) << 32); st <= M_P3; end
        M_P3: begin acc <= acc + (128'(prod) << 64); st <= M_FIN; end
        M_FIN: begin
          if (sft[127:48] != '0 || sft[47:0] > cap)
            res <= neg ? MIN48 : MAX48;
          else
            res <= neg ? -$signed(sft[47:0]) : $signed(sft[47:0]);
          done <= 1'b1;
          st <= M_IDLE;
        end
        default: st <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== design/kf3_div.sv =====
// n / d in Q16.32, truncated toward zero, saturated; restoring, one bit a cycle
module kf3_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  kf3_pkg::val_t               n,
  input  logic signed [kf3_pkg::W:0]  d,
  output logic                        done,
  output kf3_pkg::val_t               q
);
  import kf3_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t st;
  logic neg;
  logic [48:0] ud;
  logic [49:0] rem;
  logic [79:0] num;
  logic [79:0] quo;
  logic [6:0] cnt;
  logic [49:0] trial;
  logic [47:0] cap;

  always_comb begin
    trial = {rem[48:0], num[79]};
    cap = neg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        D_IDLE: if (start) begin
          if (d == '0) begin
            q <= (n > 0) ? MAX48 : ((n < 0) ? MIN48 : '0);
            done <= 1'b1;
          end else begin
            neg <= n[W-1] ^ d[W];
            ud <= d[W] ? 49'(-d) : 49'(d);
            num <= {(n[W-1] ? 48'(-n) : 48'(n)), 32'd0};
            rem <= '0;
            quo <= '0;
            cnt <= 7'd0;
            st <= D_RUN;
          end
        end
        D_RUN: begin
          num <= {num[78:0], 1'b0};
          if (trial >= {1'b0, ud}) begin
            rem <= trial - {1'b0, ud};
            quo <= {quo[78:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[78:0], 1'b0};
          end
          if (cnt == 7'd79) st <= D_FIN;
          cnt <= cnt + 7'd1;
        end
        D_FIN: begin
          if (quo[79:48] != '0 || quo[47:0] > cap) q <= neg ? MIN48 : MAX48;
          else q <= neg ? -$signed(quo[47:0]) : $signed(quo[47:0]);
          done <= 1'b1;
          st <= D_IDLE;
        end
        default: st <= D_IDLE;
      endcase
    end
  end

endmodule
